### src/sobel_gradient_direction_quantizer_defines.svh
// Assertion helpers shared by the queue and back modules.
// Both expect clk and rst_n in the scope of use.
`ifndef SOBEL_GRADIENT_DIRECTION_QUANTIZER_DEFINES_SVH
`define SOBEL_GRADIENT_DIRECTION_QUANTIZER_DEFINES_SVH

// same-cycle implication
`define SGDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sgdq_pkg.sv
`default_nettype none

package sgdq_pkg;

    localparam int PIX_W       = 8;
    localparam int CNT_W       = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int GRAD_W      = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register map
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_MIN = 13'd6;
    localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;
    localparam logic [CNT_W-1:0] WIDTH_LAST_RESET  = 12'd639;
    localparam logic [CNT_W-1:0] HEIGHT_LAST_RESET = 12'd479;

    // direction codes
    localparam logic [7:0] DIR_BORDER    = 8'd0;
    localparam logic [7:0] DIR_HORIZ     = 8'd50;
    localparam logic [7:0] DIR_DIAG_SAME = 8'd100;
    localparam logic [7:0] DIR_VERT      = 8'd150;
    localparam logic [7:0] DIR_DIAG_OPP  = 8'd200;

    localparam logic [7:0]  MAG_MAX   = 8'd255;
    // 255 * 255: at or above this the floored root saturates
    localparam logic [20:0] SAT_LIMIT = 21'd65025;

    typedef struct packed {
        logic                     interior;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     tail;   // item also closes a row
        logic                     eof;    // closing row is the frame's last
    } sgdq_task_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sgdq_fifo_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_ROOT,
        ST_MAIN,
        ST_TAIL
    } sgdq_back_state_t;

    // saturate a dimension into range and return its last index
    function automatic logic [CNT_W-1:0] dim_last(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            d = v;
            if (v < DIM_MIN) begin
                d = DIM_MIN;
            end
            else if (v > DIM_MAX) begin
                d = DIM_MAX;
            end
            dim_last = CNT_W'(d - 13'd1);
        end
    endfunction

endpackage

`default_nettype wire

### src/sobel_gradient_direction_quantizer.sv
// channel   | signals                                          | handshake
// ----------+--------------------------------------------------+-----------------
// input     | top_pixel, middle_pixel, bottom_pixel            | in_valid/in_ready
// result    | magnitude, direction_code, last_of_run,          | out_valid/out_ready
//           | end_of_frame                                     |
// config    | cfg_index, cfg_data                              | cfg_write
//
// Flow: the front takes a column item in any cycle the 4-entry queue has room.
// The back sets the pace: interior pixels take pop, four squares on one shared 11x11
// multiplier, compare, eight bit-serial root steps (none on saturation) and output;
// border pixels take pop and output; a row's last column adds a tail result.
// Reset clears counters, queue and sequencer; width/height return to 640x480.
// Stalls: a held result in the output register stalls the back only; the queue
// then fills and in_ready drops.
`default_nettype none

module sobel_gradient_direction_quantizer
    import sgdq_pkg::*;
#(
    parameter int BORDER = 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PIX_W-1:0]       top_pixel,
    input  wire logic [PIX_W-1:0]       middle_pixel,
    input  wire logic [PIX_W-1:0]       bottom_pixel,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  magnitude,
    output logic [7:0]                  direction_code,
    output logic                        last_of_run,
    output logic                        end_of_frame
);

    sgdq_fifo_status_t fifo_status;
    sgdq_task_t        push_task, head;
    logic              push, pop;

    // front: config, counters, column window, gx/gy and border flags
    sgdq_front #(
        .BORDER (BORDER)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .top_pixel    (top_pixel),
        .middle_pixel (middle_pixel),
        .bottom_pixel (bottom_pixel),
        .fifo_status  (fifo_status),
        .push         (push),
        .push_task    (push_task)
    );

    // decouples the two halves
    sgdq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .head      (head),
        .status    (fifo_status)
    );

    // back: magnitude, direction bins, result sequencing
    sgdq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .fifo_status    (fifo_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .magnitude      (magnitude),
        .direction_code (direction_code),
        .last_of_run    (last_of_run),
        .end_of_frame   (end_of_frame)
    );

endmodule

`default_nettype wire

### src/sgdq_front.sv
`default_nettype none

module sgdq_front
    import sgdq_pkg::*;
#(
    parameter int BORDER = 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PIX_W-1:0]       top_pixel,
    input  wire logic [PIX_W-1:0]       middle_pixel,
    input  wire logic [PIX_W-1:0]       bottom_pixel,
    input  wire sgdq_fifo_status_t      fifo_status,
    output logic                        push,
    output sgdq_task_t                  push_task
);

    localparam logic [CNT_W-1:0] BORDER_C = CNT_W'(BORDER);

    logic [CNT_W-1:0] width_last_reg, height_last_reg;
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [PIX_W-1:0] one_top_reg, one_mid_reg, one_bot_reg;
    logic [PIX_W-1:0] two_top_reg, two_mid_reg, two_bot_reg;

    logic             accept, last_col, last_row, row_in, col_in;
    logic [CNT_W-1:0] prev_col;
    logic [9:0]       right_sum, left_sum, top_sum, bot_sum;

    assign in_ready = !fifo_status.full;
    assign accept   = in_valid && in_ready;

    assign last_col = col_cnt_reg >= width_last_reg;
    assign last_row = row_cnt_reg >= height_last_reg;
    assign prev_col = col_cnt_reg - 12'd1;
    assign row_in   = (row_cnt_reg >= BORDER_C) && (row_cnt_reg <= height_last_reg - BORDER_C);
    assign col_in   = (prev_col >= BORDER_C) && (prev_col <= width_last_reg - BORDER_C);

    // 1-2-1 sums: right is the incoming column, left two back; top/bottom run along rows
    assign right_sum = {2'b0, top_pixel} + {1'b0, middle_pixel, 1'b0} + {2'b0, bottom_pixel};
    assign left_sum  = {2'b0, two_top_reg} + {1'b0, two_mid_reg, 1'b0} + {2'b0, two_bot_reg};
    assign top_sum   = {2'b0, two_top_reg} + {1'b0, one_top_reg, 1'b0} + {2'b0, top_pixel};
    assign bot_sum   = {2'b0, two_bot_reg} + {1'b0, one_bot_reg, 1'b0} + {2'b0, bottom_pixel};

    // column zero has no finished pixel yet
    assign push = accept && (col_cnt_reg != '0);

    always_comb
    begin
        push_task.interior = row_in && col_in;
        push_task.gx       = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        push_task.gy       = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        push_task.tail     = last_col;
        push_task.eof      = last_row;
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            if (last_col) begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + 12'd1;
            end
            else begin
                col_cnt_next = col_cnt_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_last_reg  <= WIDTH_LAST_RESET;
            height_last_reg <= HEIGHT_LAST_RESET;
            col_cnt_reg     <= '0;
            row_cnt_reg     <= '0;
            one_top_reg     <= '0;
            one_mid_reg     <= '0;
            one_bot_reg     <= '0;
            two_top_reg     <= '0;
            two_mid_reg     <= '0;
            two_bot_reg     <= '0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_last_reg  <= dim_last(cfg_data);
                    CFG_IMAGE_HEIGHT: height_last_reg <= dim_last(cfg_data);
                    default: ;
                endcase
            end
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (accept) begin
                two_top_reg <= one_top_reg;
                two_mid_reg <= one_mid_reg;
                two_bot_reg <= one_bot_reg;
                one_top_reg <= top_pixel;
                one_mid_reg <= middle_pixel;
                one_bot_reg <= bottom_pixel;
            end
        end
    end

endmodule

`default_nettype wire

### src/sgdq_fifo.sv
`default_nettype none

`include "sobel_gradient_direction_quantizer_defines.svh"

module sgdq_fifo
    import sgdq_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sgdq_task_t    push_task,
    input  wire logic          pop,
    output sgdq_task_t         head,
    output sgdq_fifo_status_t  status
);

    sgdq_task_t        entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign head         = entries[rd_ptr_reg];
    assign status.full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entries[wr_ptr_reg] <= push_task;
        end
    end

    `SGDQ_ASSERT_NOW(a_no_push_full, push, !status.full, "push into full queue")
    `SGDQ_ASSERT_NOW(a_no_pop_empty, pop, !status.empty, "pop from empty queue")
    `SGDQ_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")

endmodule

`default_nettype wire

### src/sgdq_back.sv
`default_nettype none

`include "sobel_gradient_direction_quantizer_defines.svh"

module sgdq_back
    import sgdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sgdq_task_t        head,
    input  wire sgdq_fifo_status_t fifo_status,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             magnitude,
    output logic [7:0]             direction_code,
    output logic                   last_of_run,
    output logic                   end_of_frame
);

    // multiplier steps
    localparam logic [1:0] MUL_AX = 2'd0;
    localparam logic [1:0] MUL_Y  = 2'd1;
    localparam logic [1:0] MUL_A  = 2'd2;
    localparam logic [1:0] MUL_B  = 2'd3;

    sgdq_back_state_t state_reg, state_next;
    logic [1:0]       mul_cnt_reg;
    logic [2:0]       root_cnt_reg;
    logic             out_valid_reg;

    logic             tail_reg, eof_reg, gx_pos_reg, b_le0_reg;
    logic [9:0]       ax_reg, y_reg, babs_reg;
    logic [10:0]      a_reg;
    logic [21:0]      p_ax_reg, p_y_reg, p_a_reg, p_b_reg;
    logic [15:0]      rv_reg;
    logic [10:0]      rem_reg;
    logic [7:0]       root_reg;
    logic [7:0]       mag_reg, dir_reg;
    logic [7:0]       out_mag_reg, out_dir_reg;
    logic             out_last_reg, out_eof_reg;

    logic             slot_free, load_main, load_tail;
    logic             neg;
    logic signed [GRAD_W-1:0] gxf, gyf, axs, bs;
    logic [10:0]      mul_op;
    logic [21:0]      product;
    logic [20:0]      sum;
    logic [22:0]      twice_ax2;
    logic             below_low, below_high, sat;
    logic [7:0]       dir_calc;
    logic [10:0]      rem_sh;
    logic [9:0]       trial;
    logic             ge;

    assign slot_free = !out_valid_reg || out_ready;

    // fold into the upper half plane
    assign neg = (head.gy < 0) || ((head.gy == 0) && (head.gx < 0));
    assign gxf = neg ? -head.gx : head.gx;
    assign gyf = neg ? -head.gy : head.gy;
    assign axs = (gxf < 0) ? -gxf : gxf;
    assign bs  = gyf - axs;

    always_comb
    begin
        case (mul_cnt_reg)
            MUL_AX:  mul_op = {1'b0, ax_reg};
            MUL_Y:   mul_op = {1'b0, y_reg};
            MUL_A:   mul_op = a_reg;
            default: mul_op = {1'b0, babs_reg};
        endcase
    end
    assign product = mul_op * mul_op;

    // bin edges: tan 22.5 = sqrt2 - 1, tan 67.5 = sqrt2 + 1
    assign sum        = p_ax_reg[20:0] + p_y_reg[20:0];
    assign twice_ax2  = {p_ax_reg, 1'b0};
    assign below_low  = {1'b0, p_a_reg} < twice_ax2;
    assign below_high = b_le0_reg || ({1'b0, p_b_reg} < twice_ax2);
    assign sat        = sum >= SAT_LIMIT;

    always_comb
    begin
        if ((y_reg == '0) || below_low) begin
            dir_calc = DIR_HORIZ;
        end
        else if (!below_high) begin
            dir_calc = DIR_VERT;
        end
        else begin
            dir_calc = gx_pos_reg ? DIR_DIAG_SAME : DIR_DIAG_OPP;
        end
    end

    // one root bit a cycle
    assign rem_sh = {rem_reg[8:0], rv_reg[15:14]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= {1'b0, trial};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_status.empty) begin
                    state_next = head.interior ? ST_MUL : ST_MAIN;
                end
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == MUL_B) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = sat ? ST_MAIN : ST_ROOT;
            ST_ROOT:
            begin
                if (root_cnt_reg == '1) begin
                    state_next = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                if (slot_free) begin
                    state_next = tail_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        load_main = 1'b0;
        load_tail = 1'b0;
        case (state_reg)
            ST_IDLE: pop       = !fifo_status.empty;
            ST_MAIN: load_main = slot_free;
            ST_TAIL: load_tail = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mul_cnt_reg   <= '0;
            root_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (pop) begin
                mul_cnt_reg <= '0;
            end
            else if (state_reg == ST_MUL) begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
            end
            if (state_reg == ST_CMP) begin
                root_cnt_reg <= '0;
            end
            else if (state_reg == ST_ROOT) begin
                root_cnt_reg <= root_cnt_reg + 1'b1;
            end
            if (load_main || load_tail) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            tail_reg   <= head.tail;
            eof_reg    <= head.eof;
            ax_reg     <= axs[9:0];
            y_reg      <= gyf[9:0];
            a_reg      <= {1'b0, gyf[9:0]} + {1'b0, axs[9:0]};
            babs_reg   <= (bs < 0) ? 10'(-bs) : bs[9:0];
            b_le0_reg  <= bs <= 0;
            gx_pos_reg <= gxf > 0;
            mag_reg    <= '0;
            dir_reg    <= DIR_BORDER;
        end
        if (state_reg == ST_MUL) begin
            case (mul_cnt_reg)
                MUL_AX:  p_ax_reg <= product;
                MUL_Y:   p_y_reg  <= product;
                MUL_A:   p_a_reg  <= product;
                default: p_b_reg  <= product;
            endcase
        end
        if (state_reg == ST_CMP) begin
            dir_reg  <= dir_calc;
            mag_reg  <= MAG_MAX;
            rv_reg   <= sum[15:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == ST_ROOT) begin
            rv_reg   <= {rv_reg[13:0], 2'b00};
            rem_reg  <= ge ? rem_sh - {1'b0, trial} : rem_sh;
            root_reg <= {root_reg[6:0], ge};
            if (root_cnt_reg == '1) begin
                mag_reg <= {root_reg[6:0], ge};
            end
        end
        if (load_main) begin
            out_mag_reg  <= mag_reg;
            out_dir_reg  <= dir_reg;
            out_last_reg <= !tail_reg;
            out_eof_reg  <= 1'b0;
        end
        else if (load_tail) begin
            out_mag_reg  <= '0;
            out_dir_reg  <= DIR_BORDER;
            out_last_reg <= 1'b1;
            out_eof_reg  <= eof_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign magnitude      = out_mag_reg;
    assign direction_code = out_dir_reg;
    assign last_of_run    = out_last_reg;
    assign end_of_frame   = out_eof_reg;

    `SGDQ_ASSERT_NOW(a_tail_needs_flag, state_reg == ST_TAIL, tail_reg, "row close without tail")
    `SGDQ_ASSERT_NOW(a_eof_is_last, out_valid_reg && out_eof_reg, out_last_reg, "frame end not last of run")
    `SGDQ_ASSERT_NEXT(a_main_then_tail, load_main && tail_reg, state_reg == ST_TAIL, "tail result skipped")

endmodule

`default_nettype wire
